// ===== rtl/nlm_pkg.sv =====
// Shared constants, operation and status codes of the named lock manager.
`default_nettype none
package nlm_pkg;
    localparam int LOCK_ENTRIES_DEF     = 16;
    localparam int WAITERS_PER_LOCK_DEF = 8;
    localparam int CLIENT_BITS_DEF      = 8;
    localparam int KEY_BITS_DEF         = 32;

    // Field widths at the ports
    localparam int OP_W     = 2;
    localparam int CLIENT_W = 8;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_GONE    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TBL_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_Q_FULL   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/named_lock_manager_fifo_unit.sv =====
// Named lock manager: lock table scan, FIFO waiter queues and result sequencer.
// One request is handled at a time. Lookup walks the lock table one entry
// at a time (memory read, then compare); a waiter search reads and compares
// the queue slots in turn, and dropping a waiter reads each later slot and
// writes it one slot nearer the head. Client-gone always walks the whole
// table and performs each handoff on the way. Each status word waits in an
// output register while the next request is taken; tlast marks the final
// word caused by a request. Every request must be tagged with an operation
// in tuser; code 3 is swallowed without a word. No clearing pass is needed
// after reset.
`default_nettype none
module named_lock_manager_fifo_unit #(
    parameter int LOCK_ENTRIES     = nlm_pkg::LOCK_ENTRIES_DEF,
    parameter int WAITERS_PER_LOCK = nlm_pkg::WAITERS_PER_LOCK_DEF,
    parameter int CLIENT_BITS      = nlm_pkg::CLIENT_BITS_DEF,
    parameter int KEY_BITS         = nlm_pkg::KEY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // client_id, lock_key, nonblocking
    input  wire logic [1:0]  s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // notify_client, notify_key
    output logic [1:0]       m_axis_tuser,  // status
    output logic             m_axis_tlast   // last
);
    localparam int CB   = (CLIENT_BITS < nlm_pkg::CLIENT_W) ? CLIENT_BITS : nlm_pkg::CLIENT_W;
    localparam int KB   = (KEY_BITS < nlm_pkg::KEY_W) ? KEY_BITS : nlm_pkg::KEY_W;
    localparam int EW   = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int CW   = $clog2(WAITERS_PER_LOCK + 1);
    localparam int QD   = LOCK_ENTRIES * WAITERS_PER_LOCK;
    localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
    localparam logic [EW-1:0] LAST_E = EW'(LOCK_ENTRIES - 1);
    localparam logic [CW-1:0] QMAX   = CW'(WAITERS_PER_LOCK);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERD   = 4'd1;
    localparam logic [3:0] S_ECMP  = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_QCMP  = 4'd4;
    localparam logic [3:0] S_ADEC  = 4'd5;
    localparam logic [3:0] S_HRD   = 4'd6;
    localparam logic [3:0] S_HEV   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SWR   = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_FLUSH = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [CB-1:0] r_c, n_c;
    logic [KB-1:0] r_key, n_key;
    logic          r_nb, n_nb;
    logic [EW-1:0] r_e, n_e;
    logic [EW-1:0] r_free, n_free;
    logic          r_free_ok, n_free_ok;
    logic [CW-1:0] r_j, n_j;
    logic [KB-1:0] r_ekey, n_ekey;
    logic          r_pend, n_pend;
    logic [CB-1:0] r_pc, n_pc;
    logic [KB-1:0] r_pk, n_pk;
    logic [1:0]    r_ps, n_ps;
    logic          r_valid [LOCK_ENTRIES];
    logic [CW-1:0] r_cnt   [LOCK_ENTRIES];
    logic          r_ov;
    logic [CB-1:0] r_oc;
    logic [KB-1:0] r_ok;
    logic [1:0]    r_os;
    logic          r_ol;

    logic          accept;
    logic          out_free;
    logic          push;
    logic          push_last;
    logic          v_cur;
    logic [CW-1:0] cnt_cur;
    logic [CW:0]   j_inc;
    logic          hit;
    logic [EW-1:0] free_idx;

    // valid and count updates
    logic          set_valid, clr_valid;
    logic [EW-1:0] valid_idx;
    logic          cnt_inc, cnt_dec, cnt_zero;

    logic [KB-1:0] e_rkey;
    logic [CB-1:0] e_rown;
    logic          e_we;
    logic [EW-1:0] e_waddr;
    logic [KB-1:0] e_wkey;
    logic [CB-1:0] e_wown;

    logic [CB-1:0] q_rd;
    logic [CW-1:0] q_rslot, q_wslot;
    logic          q_we;
    logic [CB-1:0] q_wdata;
    logic [QAW-1:0] q_raddr, q_waddr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign v_cur         = r_valid[r_e];
    assign cnt_cur       = r_cnt[r_e];
    assign j_inc         = {1'b0, r_j} + (CW+1)'(1);
    assign free_idx      = r_free_ok ? r_free : r_e;

    assign q_raddr = QAW'(r_e) * QAW'(WAITERS_PER_LOCK) + QAW'(q_rslot);
    assign q_waddr = QAW'(r_e) * QAW'(WAITERS_PER_LOCK) + QAW'(q_wslot);

    nlm_ent_tbl #(
        .ENTRIES (LOCK_ENTRIES),
        .EW      (EW),
        .KB      (KB),
        .CB      (CB)
    ) u_ent (
        .i_clk      (i_clk),
        .i_rd_addr  (r_e),
        .o_rd_key   (e_rkey),
        .o_rd_owner (e_rown),
        .i_wr_en    (e_we),
        .i_wr_addr  (e_waddr),
        .i_wr_key   (e_wkey),
        .i_wr_owner (e_wown)
    );

    nlm_wait_q #(
        .DEPTH (QD),
        .AW    (QAW),
        .CB    (CB)
    ) u_wq (
        .i_clk     (i_clk),
        .i_rd_addr (q_raddr),
        .o_rd_data (q_rd),
        .i_wr_en   (q_we),
        .i_wr_addr (q_waddr),
        .i_wr_data (q_wdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_c       = r_c;
        n_key     = r_key;
        n_nb      = r_nb;
        n_e       = r_e;
        n_free    = r_free;
        n_free_ok = r_free_ok;
        n_j       = r_j;
        n_ekey    = r_ekey;
        n_pend    = r_pend;
        n_pc      = r_pc;
        n_pk      = r_pk;
        n_ps      = r_ps;
        push      = 1'b0;
        push_last = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        valid_idx = r_e;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        cnt_zero  = 1'b0;
        e_we      = 1'b0;
        e_waddr   = r_e;
        e_wkey    = r_key;
        e_wown    = r_c;
        q_rslot   = r_j;
        q_wslot   = r_j;
        q_we      = 1'b0;
        q_wdata   = r_c;
        hit       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = s_axis_tuser;
                    n_c       = s_axis_tdata[CB-1:0];
                    n_key     = s_axis_tdata[8 +: KB];
                    n_nb      = s_axis_tdata[40];
                    n_e       = '0;
                    n_free_ok = 1'b0;
                    n_state   = (s_axis_tuser == nlm_pkg::OP_NONE) ? S_IDLE : S_ERD;
                end
            end
            S_ERD: begin
                n_state = S_ECMP;
            end
            S_ECMP: begin
                n_ekey = e_rkey;
                hit = v_cur && ((r_op == nlm_pkg::OP_GONE) ? (e_rown == r_c) : (e_rkey == r_key));
                if (hit) begin
                    if (e_rown == r_c) begin
                        if (r_op == nlm_pkg::OP_ACQUIRE) begin
                            n_state = S_FIN;
                        end else if (cnt_cur != '0) begin
                            n_state = r_pend ? S_FLUSH : S_HRD;
                        end else begin
                            clr_valid = 1'b1;
                            n_state   = S_NEXT;
                        end
                    end else if (cnt_cur == '0) begin
                        n_state = (r_op == nlm_pkg::OP_ACQUIRE) ? S_ADEC : S_FIN;
                    end else begin
                        n_j     = '0;
                        n_state = S_QRD;
                    end
                end else if (r_e == LAST_E) begin
                    if (r_op == nlm_pkg::OP_ACQUIRE) begin
                        n_pend = 1'b1;
                        n_pc   = r_c;
                        n_pk   = r_key;
                        if (r_free_ok || !v_cur) begin
                            // create the lock in the lowest free entry
                            e_we      = 1'b1;
                            e_waddr   = free_idx;
                            set_valid = 1'b1;
                            cnt_zero  = 1'b1;
                            valid_idx = free_idx;
                            n_ps      = nlm_pkg::ST_ACQUIRED;
                        end else begin
                            n_ps = nlm_pkg::ST_TBL_FULL;
                        end
                    end
                    n_state = S_FIN;
                end else begin
                    if (!v_cur && !r_free_ok) begin
                        n_free    = r_e;
                        n_free_ok = 1'b1;
                    end
                    n_e     = r_e + EW'(1);
                    n_state = S_ERD;
                end
            end
            S_QRD: begin
                n_state = S_QCMP;
            end
            S_QCMP: begin
                if (q_rd == r_c) begin
                    // drop from the queue on release, leave as is on acquire
                    n_state = (r_op == nlm_pkg::OP_ACQUIRE) ? S_FIN : S_SRD;
                end else if (j_inc == {1'b0, cnt_cur}) begin
                    n_state = (r_op == nlm_pkg::OP_ACQUIRE) ? S_ADEC : S_FIN;
                end else begin
                    n_j     = j_inc[CW-1:0];
                    n_state = S_QRD;
                end
            end
            S_ADEC: begin
                n_pc = r_c;
                n_pk = r_key;
                if (r_nb) begin
                    n_pend = 1'b1;
                    n_ps   = nlm_pkg::ST_BUSY;
                end else if (cnt_cur >= QMAX) begin
                    n_pend = 1'b1;
                    n_ps   = nlm_pkg::ST_Q_FULL;
                end else begin
                    q_we    = 1'b1;
                    q_wslot = cnt_cur;
                    cnt_inc = 1'b1;
                end
                n_state = S_FIN;
            end
            S_HRD: begin
                q_rslot = '0;
                n_state = S_HEV;
            end
            S_HEV: begin
                // hand the lock to the oldest waiter
                e_we    = 1'b1;
                e_wkey  = r_ekey;
                e_wown  = q_rd;
                n_pend  = 1'b1;
                n_pc    = q_rd;
                n_pk    = r_ekey;
                n_ps    = nlm_pkg::ST_ACQUIRED;
                n_j     = '0;
                n_state = S_SRD;
            end
            S_SRD: begin
                q_rslot = j_inc[CW-1:0];
                if (j_inc < {1'b0, cnt_cur}) begin
                    n_state = S_SWR;
                end else begin
                    cnt_dec = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_SWR: begin
                q_we    = 1'b1;
                q_wdata = q_rd;
                n_j     = j_inc[CW-1:0];
                n_state = S_SRD;
            end
            S_NEXT: begin
                if (r_op == nlm_pkg::OP_GONE && r_e != LAST_E) begin
                    n_e     = r_e + EW'(1);
                    n_state = S_ERD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    push    = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_HRD;
                end
            end
            S_FIN: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < LOCK_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_cnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (push) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (set_valid) begin
                r_valid[valid_idx] <= 1'b1;
            end else if (clr_valid) begin
                r_valid[valid_idx] <= 1'b0;
            end
            if (cnt_zero) begin
                r_cnt[valid_idx] <= '0;
            end else if (cnt_inc) begin
                r_cnt[r_e] <= cnt_cur + CW'(1);
            end else if (cnt_dec) begin
                r_cnt[r_e] <= cnt_cur - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_c       <= n_c;
        r_key     <= n_key;
        r_nb      <= n_nb;
        r_e       <= n_e;
        r_free    <= n_free;
        r_free_ok <= n_free_ok;
        r_j       <= n_j;
        r_ekey    <= n_ekey;
        r_pc      <= n_pc;
        r_pk      <= n_pk;
        r_ps      <= n_ps;
        if (push) begin
            r_oc <= r_pc;
            r_ok <= r_pk;
            r_os <= r_ps;
            r_ol <= push_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {32'(r_ok), 8'(r_oc)};
    assign m_axis_tuser  = r_os;
    assign m_axis_tlast  = r_ol;
endmodule
`default_nettype wire

// ===== rtl/nlm_ent_tbl.sv =====
// Lock table memory: key and owner of each entry, registered read.
`default_nettype none
module nlm_ent_tbl #(
    parameter int ENTRIES = nlm_pkg::LOCK_ENTRIES_DEF,
    parameter int EW      = 4,
    parameter int KB      = nlm_pkg::KEY_BITS_DEF,
    parameter int CB      = nlm_pkg::CLIENT_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic [EW-1:0] i_rd_addr,
    output logic      [KB-1:0] o_rd_key,
    output logic      [CB-1:0] o_rd_owner,
    input  wire logic          i_wr_en,
    input  wire logic [EW-1:0] i_wr_addr,
    input  wire logic [KB-1:0] i_wr_key,
    input  wire logic [CB-1:0] i_wr_owner
);
    logic [KB+CB-1:0] mem [ENTRIES];
    logic [KB+CB-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_key, i_wr_owner};
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_key   = r_rd[KB+CB-1:CB];
    assign o_rd_owner = r_rd[CB-1:0];
endmodule
`default_nettype wire

// ===== rtl/nlm_wait_q.sv =====
// Waiter queue memory: one slot row per lock entry, registered read.
`default_nettype none
module nlm_wait_q #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CB    = nlm_pkg::CLIENT_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [CB-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [CB-1:0] i_wr_data
);
    logic [CB-1:0] mem [DEPTH];
    logic [CB-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the named lock manager: lock table predictor and result scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int N_ENT  = 16;
    localparam int N_WAIT = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [nlm_pkg::CLIENT_W-1:0] client;
        logic [nlm_pkg::KEY_W-1:0]    key;
        logic [nlm_pkg::STATUS_W-1:0] status;
        logic                         last;
    } t_notice;

    class t_lock_scoreboard;
        bit                        held[N_ENT];
        logic [nlm_pkg::KEY_W-1:0] key_of[N_ENT];
        logic [7:0]                owner[N_ENT];
        int                        n_wait[N_ENT];
        logic [7:0]                fifo[N_ENT][N_WAIT];
        t_notice                   pending[$];
        int                        errors;
        int                        seen;

        function void post(logic [7:0] c, logic [31:0] k, logic [1:0] st);
            t_notice n;
            n.client = c; n.key = k; n.status = st; n.last = 1'b0;
            pending.push_back(n);
        endfunction

        function int lookup(logic [31:0] k);
            for (int e = 0; e < N_ENT; e++)
                if (held[e] && key_of[e] == k) return e;
            return -1;
        endfunction

        function void drop_slot(int e, int pos);
            for (int j = pos; j + 1 < n_wait[e]; j++) fifo[e][j] = fifo[e][j+1];
            n_wait[e]--;
        endfunction

        function void give_up(int e, logic [7:0] c);
            if (owner[e] == c) begin
                if (n_wait[e] > 0) begin
                    owner[e] = fifo[e][0];
                    drop_slot(e, 0);
                    post(owner[e], key_of[e], nlm_pkg::ST_ACQUIRED);
                end else begin
                    held[e] = 0;
                end
                return;
            end
            for (int j = 0; j < n_wait[e]; j++)
                if (fifo[e][j] == c) begin
                    drop_slot(e, j);
                    return;
                end
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] c, logic [31:0] k, bit nb);
            int e;
            int before_n;
            before_n = pending.size();
            if (op == nlm_pkg::OP_ACQUIRE) begin
                e = lookup(k);
                if (e >= 0) begin
                    if (owner[e] == c) return;
                    for (int j = 0; j < n_wait[e]; j++) if (fifo[e][j] == c) return;
                    if (nb) post(c, k, nlm_pkg::ST_BUSY);
                    else if (n_wait[e] >= N_WAIT) post(c, k, nlm_pkg::ST_Q_FULL);
                    else begin
                        fifo[e][n_wait[e]] = c;
                        n_wait[e]++;
                    end
                end else begin
                    e = -1;
                    for (int i = 0; i < N_ENT && e < 0; i++) if (!held[i]) e = i;
                    if (e >= 0) begin
                        held[e] = 1; key_of[e] = k; owner[e] = c; n_wait[e] = 0;
                        post(c, k, nlm_pkg::ST_ACQUIRED);
                    end else post(c, k, nlm_pkg::ST_TBL_FULL);
                end
            end else if (op == nlm_pkg::OP_RELEASE) begin
                e = lookup(k);
                if (e >= 0) give_up(e, c);
            end else if (op == nlm_pkg::OP_GONE) begin
                for (int i = 0; i < N_ENT; i++)
                    if (held[i] && owner[i] == c) give_up(i, c);
            end
            if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_notice(t_notice got);
            t_notice exp;
            seen++;
            if (pending.size() == 0) begin
                $error("unexpected word: client %0d key %h status %0d",
                       got.client, got.key, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (exp.client !== got.client) begin
                $error("notify_client: expected %0d, got %0d", exp.client, got.client);
                errors++;
            end
            if (exp.key !== got.key) begin
                $error("notify_key: expected %h, got %h", exp.key, got.key);
                errors++;
            end
            if (exp.status !== got.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (exp.last !== got.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // client_id, lock_key, nonblocking
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // notify_client, notify_key
    logic [1:0]  m_axis_tuser;   // status
    logic        m_axis_tlast;

    t_lock_scoreboard sb;
    int  idle_cycles;
    int  sent;
    int  op_count[4];
    bit  sink_quiet;

    named_lock_manager_fifo_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until taken
    task automatic send(logic [1:0] op, logic [7:0] c, logic [31:0] k, bit nb);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, nb, k, c};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, c, k, nb);
        op_count[op]++;
        sent++;
    endtask

    task automatic send_gapped(logic [1:0] op, logic [7:0] c, logic [31:0] k, bit nb,
                               bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send(op, c, k, nb);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Sink: random stalls, with a quiet stretch where it always accepts
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int g;
            g = sink_quiet ? 0 : gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_notice got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.client = m_axis_tdata[7:0];
            got.key    = m_axis_tdata[39:8];
            got.status = m_axis_tuser;
            got.last   = m_axis_tlast;
            sb.check_notice(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Random keys come from a small pool so that locks collide often
    function automatic logic [31:0] pool_key(int i);
        case (i)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hA5A5_5A5A;
            default: return {28'h1234_567, i[3:0]} ^ {i[3:0], 28'h0};
        endcase
    endfunction

    initial begin
        logic [1:0]  op;
        logic [7:0]  c;
        logic [31:0] k;
        int          r;
        sb = new();
        sink_quiet = 1'b0;
        sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = nlm_pkg::OP_ACQUIRE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: grant, repeat by owner, busy, queue, queue full, handoff
        send(nlm_pkg::OP_ACQUIRE, 8'd0,   32'h0000_0000, 1'b0);
        send(nlm_pkg::OP_ACQUIRE, 8'd0,   32'h0000_0000, 1'b0);
        send(nlm_pkg::OP_ACQUIRE, 8'd255, 32'h0000_0000, 1'b1);
        for (int i = 1; i <= 8; i++) send(nlm_pkg::OP_ACQUIRE, i[7:0], 32'h0000_0000, 1'b0);
        send(nlm_pkg::OP_ACQUIRE, 8'd3,   32'h0000_0000, 1'b0);  // already waiting
        send(nlm_pkg::OP_ACQUIRE, 8'd255, 32'h0000_0000, 1'b0);  // queue full
        send(nlm_pkg::OP_RELEASE, 8'd4,   32'h0000_0000, 1'b0);  // waiter drops out
        send(nlm_pkg::OP_RELEASE, 8'd0,   32'h0000_0000, 1'b0);  // handoff to 1
        send(nlm_pkg::OP_RELEASE, 8'd77,  32'h0000_0000, 1'b0);  // not involved
        send(nlm_pkg::OP_RELEASE, 8'd1,   32'hFFFF_FFFF, 1'b1);  // unknown key
        send(nlm_pkg::OP_NONE,    8'hAA,  32'h5555_AAAA, 1'b1);
        // Fill the table, overflow it, then a client gone with several handoffs
        for (int i = 1; i < 16; i++)
            send(nlm_pkg::OP_ACQUIRE, 8'd200, 32'hFFFF_FF00 + i, 1'b0);
        send(nlm_pkg::OP_ACQUIRE, 8'd201, 32'hFFFF_FFFF, 1'b0);  // table full
        send(nlm_pkg::OP_ACQUIRE, 8'd201, 32'hFFFF_FF01, 1'b0);
        send(nlm_pkg::OP_ACQUIRE, 8'd202, 32'hFFFF_FF02, 1'b0);
        send(nlm_pkg::OP_GONE,    8'd200, 32'h0000_0000, 1'b0);
        pause_until_drained();

        // Drop everything left so the random phase starts from an empty table
        for (int i = 0; i < 256; i++) begin
            c = i[7:0];
            if (i inside {[0:8], [200:202]}) send(nlm_pkg::OP_GONE, c, 32'd0, 1'b0);
        end
        pause_until_drained();

        for (int n = 0; n < 110; n++) begin
            if (n == 60) sink_quiet = 1'b1;
            if (n == 90) sink_quiet = 1'b0;
            if (n == 100) pause_until_drained();
            r = $urandom_range(0, 99);
            c = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0) c = 8'($urandom);
            k = pool_key($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0) k = $urandom;
            if (r < 50) op = nlm_pkg::OP_ACQUIRE;
            else if (r < 80) op = nlm_pkg::OP_RELEASE;
            else if (r < 95) op = nlm_pkg::OP_GONE;
            else op = nlm_pkg::OP_NONE;
            send_gapped(op, c, k, $urandom_range(0, 3) == 0, n < 60 || n >= 90);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d requests (acquire %0d, release %0d, gone %0d, unused %0d);",
                 sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("checked %0d status words, %0d still outstanding.",
                 sb.seen, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/nlm_pkg.sv
rtl/nlm_ent_tbl.sv
rtl/nlm_wait_q.sv
rtl/named_lock_manager_fifo_unit.sv
sim/tb_top.sv
